// ===== hdl/tracker_effect_translator_macros.svh =====
// assertion macros for the tracker effect translator
// clocked on clk and held off while rst_n is low; define ASSERT_OFF to drop them
`ifndef TRACKER_EFFECT_TRANSLATOR_MACROS_SVH
`define TRACKER_EFFECT_TRANSLATOR_MACROS_SVH

`ifndef ASSERT_OFF

// condition must hold at every clock edge out of reset
`define TET_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define TET_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent in a cycle implies consequent in the next cycle
`define TET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TET_ASSERT(lbl, cond, msg)
`define TET_ASSERT_IMPLY(lbl, ante, cons, msg)
`define TET_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/tet_pkg.sv =====
// shared types, codes and helpers of the tracker effect translator
// no dependencies; used by tet_mod_map, tet_xlate and the top level
`default_nettype none

package tet_pkg;

  // source / result format codes
  localparam logic [1:0] FMT_MOD = 2'd0;
  localparam logic [1:0] FMT_S3M = 2'd1;
  localparam logic [1:0] FMT_IT  = 2'd2;
  localparam logic [1:0] FMT_BAD = 2'd3;

  // mod command codes
  localparam logic [7:0] MOD_ARPEGGIO   = 8'h00;
  localparam logic [7:0] MOD_PORTA_UP   = 8'h01;
  localparam logic [7:0] MOD_PORTA_DN   = 8'h02;
  localparam logic [7:0] MOD_TONE_PORTA = 8'h03;
  localparam logic [7:0] MOD_VIBRATO    = 8'h04;
  localparam logic [7:0] MOD_PORTA_VSL  = 8'h05;
  localparam logic [7:0] MOD_VIB_VSL    = 8'h06;
  localparam logic [7:0] MOD_TREMOLO    = 8'h07;
  localparam logic [7:0] MOD_PAN        = 8'h08;
  localparam logic [7:0] MOD_OFFSET     = 8'h09;
  localparam logic [7:0] MOD_VOL_SLIDE  = 8'h0A;
  localparam logic [7:0] MOD_JUMP       = 8'h0B;
  localparam logic [7:0] MOD_SET_VOL    = 8'h0C;
  localparam logic [7:0] MOD_BREAK      = 8'h0D;
  localparam logic [7:0] MOD_EXTENDED   = 8'h0E;
  localparam logic [7:0] MOD_SPEED      = 8'h0F;

  // mod extended subcommand codes (high nybble of info)
  localparam logic [3:0] ESUB_FILTER    = 4'h0;
  localparam logic [3:0] ESUB_FINE_UP   = 4'h1;
  localparam logic [3:0] ESUB_FINE_DN   = 4'h2;
  localparam logic [3:0] ESUB_GLISS     = 4'h3;
  localparam logic [3:0] ESUB_VIB_WAVE  = 4'h4;
  localparam logic [3:0] ESUB_FINETUNE  = 4'h5;
  localparam logic [3:0] ESUB_LOOP      = 4'h6;
  localparam logic [3:0] ESUB_TREM_WAVE = 4'h7;
  localparam logic [3:0] ESUB_RETRIG    = 4'h9;
  localparam logic [3:0] ESUB_FVOL_UP   = 4'hA;
  localparam logic [3:0] ESUB_FVOL_DN   = 4'hB;
  localparam logic [3:0] ESUB_INVERT    = 4'hF;

  // letter commands
  localparam logic [7:0] LTR_A = 8'h41;
  localparam logic [7:0] LTR_B = 8'h42;
  localparam logic [7:0] LTR_C = 8'h43;
  localparam logic [7:0] LTR_D = 8'h44;
  localparam logic [7:0] LTR_E = 8'h45;
  localparam logic [7:0] LTR_F = 8'h46;
  localparam logic [7:0] LTR_G = 8'h47;
  localparam logic [7:0] LTR_H = 8'h48;
  localparam logic [7:0] LTR_J = 8'h4A;
  localparam logic [7:0] LTR_K = 8'h4B;
  localparam logic [7:0] LTR_L = 8'h4C;
  localparam logic [7:0] LTR_O = 8'h4F;
  localparam logic [7:0] LTR_Q = 8'h51;
  localparam logic [7:0] LTR_R = 8'h52;
  localparam logic [7:0] LTR_S = 8'h53;
  localparam logic [7:0] LTR_T = 8'h54;
  localparam logic [7:0] LTR_X = 8'h58;

  // letter range of s3m / it commands
  localparam logic [7:0] LETTER_FIRST = 8'd1;
  localparam logic [7:0] LETTER_LAST  = 8'd26;
  localparam logic [7:0] LETTER_BASE  = 8'd64;

  // clamp and tempo limits
  localparam logic [7:0] SLIDE_LIMIT = 8'hE0;
  localparam logic [7:0] SLIDE_CLAMP = 8'hDF;
  localparam logic [7:0] TEMPO_MIN   = 8'h20;

  // translated mod effect
  typedef struct packed {
    logic       present;
    logic [7:0] cmd;
    logic [7:0] info;
  } tet_mod_res_t;

  // one result beat
  typedef struct packed {
    logic       effect_present;
    logic       format_error;
    logic [1:0] fmt;
    logic [7:0] cmd;
    logic [7:0] info;
    logic       volume_write;
    logic [7:0] volume_value;
    logic       keep_note;
    logic       keep_volume;
  } tet_result_t;

  // pan 0..255 to 0..128: (v * 128) / 255 via exact reciprocal trick
  function automatic logic [7:0] pan_scale(input logic [7:0] v);
    logic [15:0] x;
    logic [15:0] s;
    begin
      x = {1'b0, v, 7'd0};
      s = x + (x >> 8) + 16'd1;
      pan_scale = s[15:8];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tet_mod_map.sv =====
// mod command to letter command mapping, pure combinational
// depends on tet_pkg
`default_nettype none

module tet_mod_map (
  input  wire logic [7:0]           cmd,
  input  wire logic [7:0]           info,
  output tet_pkg::tet_mod_res_t     res
);
  import tet_pkg::*;

  logic [3:0] lo;
  logic [3:0] hi;
  logic [3:0] lo_vol;

  assign lo     = info[3:0];
  assign hi     = info[7:4];
  // fine volume slide of F is treated as E
  assign lo_vol = (lo == 4'hF) ? 4'hE : lo;

  // main command decode
  always_comb begin
    res.present = 1'b1;
    res.cmd     = cmd;
    res.info    = info;
    case (cmd)
      MOD_ARPEGGIO: begin
        res.present = (info != 8'd0);
        res.cmd     = LTR_J;
      end
      MOD_PORTA_UP: begin
        res.cmd = LTR_F;
        if (info >= SLIDE_LIMIT) res.info = SLIDE_CLAMP;
      end
      MOD_PORTA_DN: begin
        res.cmd = LTR_E;
        if (info >= SLIDE_LIMIT) res.info = SLIDE_CLAMP;
      end
      MOD_TONE_PORTA: res.cmd = LTR_G;
      MOD_VIBRATO:    res.cmd = LTR_H;
      MOD_PORTA_VSL:  res.cmd = LTR_L;
      MOD_VIB_VSL:    res.cmd = LTR_K;
      MOD_TREMOLO:    res.cmd = LTR_R;
      MOD_PAN: begin
        res.cmd  = LTR_X;
        res.info = pan_scale(info);
      end
      MOD_OFFSET:     res.cmd = LTR_O;
      MOD_VOL_SLIDE:  res.cmd = LTR_D;
      MOD_JUMP:       res.cmd = LTR_B;
      MOD_BREAK:      res.cmd = LTR_C;
      MOD_EXTENDED: begin
        // extended subcommands keyed on the high nybble
        case (hi)
          ESUB_FILTER: res.present = 1'b0;
          ESUB_FINE_UP, ESUB_FINE_DN: begin
            res.present = (lo != 4'h0);
            res.cmd     = (hi == ESUB_FINE_UP) ? LTR_F : LTR_E;
            res.info    = (lo == 4'hF) ? 8'hFE : (info | 8'hF0);
          end
          ESUB_GLISS: begin
            res.cmd  = LTR_S;
            res.info = {4'h1, lo};
          end
          ESUB_VIB_WAVE: begin
            res.cmd  = LTR_S;
            res.info = {4'h3, lo};
          end
          ESUB_FINETUNE: begin
            res.cmd  = LTR_S;
            res.info = {4'h2, lo ^ 4'h8};
          end
          ESUB_LOOP: begin
            res.cmd  = LTR_S;
            res.info = {4'hB, lo};
          end
          ESUB_TREM_WAVE: begin
            res.cmd  = LTR_S;
            res.info = {4'h4, lo};
          end
          ESUB_RETRIG: begin
            res.present = (lo != 4'h0);
            res.cmd     = LTR_Q;
            res.info    = {4'h0, lo};
          end
          ESUB_FVOL_UP: begin
            res.cmd  = LTR_D;
            res.info = {lo_vol, 4'hF};
          end
          ESUB_FVOL_DN: begin
            res.cmd  = LTR_D;
            res.info = {4'hF, lo_vol};
          end
          // invert loop passes through untouched
          ESUB_INVERT: res.cmd = cmd;
          default:     res.cmd = LTR_S;
        endcase
      end
      MOD_SPEED: res.cmd = (info >= TEMPO_MIN) ? LTR_T : LTR_A;
      default:   res.cmd = cmd;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/tet_xlate.sv =====
// format dispatch, volume write and keep flags for one effect
// depends on tet_pkg and tet_mod_map
`default_nettype none

module tet_xlate (
  input  wire logic [1:0]        source_format,
  input  wire logic [7:0]        cmd,
  input  wire logic [7:0]        info,
  output tet_pkg::tet_result_t   res
);
  import tet_pkg::*;

  tet_mod_res_t mod_res;
  logic [7:0]   kcmd;

  tet_mod_map u_mod_map (
    .cmd  (cmd),
    .info (info),
    .res  (mod_res)
  );

  // pick the translation by source format
  always_comb begin
    res = '0;
    case (source_format)
      FMT_MOD: begin
        if (cmd == MOD_SET_VOL) begin
          res.volume_write = 1'b1;
          res.volume_value = info;
        end else if (mod_res.present) begin
          res.effect_present = 1'b1;
          res.fmt            = FMT_S3M;
          res.cmd            = mod_res.cmd;
          res.info           = mod_res.info;
        end
      end
      FMT_S3M, FMT_IT: begin
        if (cmd >= LETTER_FIRST && cmd <= LETTER_LAST) begin
          res.effect_present = 1'b1;
          res.fmt            = source_format;
          res.cmd            = cmd + LETTER_BASE;
          res.info           = info;
        end
      end
      default: res.format_error = 1'b1;
    endcase
    // keep flags follow the final letter
    kcmd = res.cmd;
    res.keep_note   = res.effect_present && (kcmd == LTR_G || kcmd == LTR_L);
    res.keep_volume = res.effect_present &&
                      (kcmd == LTR_D || kcmd == LTR_K || kcmd == LTR_L);
  end

endmodule

`default_nettype wire

// ===== hdl/tracker_effect_translator.sv =====
// tracker effect translator: an input beat reaches the result beat through the
// input register, then the result register; one beat per cycle while out_stall is low.
// a result held by out_stall lets one more beat wait in the input register.
// rst_n (synchronous, active low) clears both valid flags; payload is not reset
// depends on tet_pkg, tet_xlate and tracker_effect_translator_macros.svh
`default_nettype none

module tracker_effect_translator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_source_format,
  input  wire logic [7:0] in_command,
  input  wire logic [7:0] in_info,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_effect_present,
  output logic            out_format_error,
  output logic [1:0]      out_format,
  output logic [7:0]      out_command,
  output logic [7:0]      out_info,
  output logic            out_volume_write,
  output logic [7:0]      out_volume_value,
  output logic            out_keep_note,
  output logic            out_keep_volume
);
  import tet_pkg::*;

  `include "tracker_effect_translator_macros.svh"

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [1:0]  s1_fmt_r;
  logic [7:0]  s1_cmd_r;
  logic [7:0]  s1_info_r;
  logic        s2_valid_r;
  logic        s2_valid_nxt;
  tet_result_t s2_res_r;
  tet_result_t xl_res;
  logic        s2_load;
  logic        s1_load;

  // handshake: result stage takes a beat when empty or draining
  assign s2_load  = s1_valid_r && (!s2_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_load || (s1_valid_r && !s2_load);
    s2_valid_nxt = s2_load || (s2_valid_r && out_stall);
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_fmt_r  <= in_source_format;
      s1_cmd_r  <= in_command;
      s1_info_r <= in_info;
    end
  end

  tet_xlate u_xlate (
    .source_format (s1_fmt_r),
    .cmd           (s1_cmd_r),
    .info          (s1_info_r),
    .res           (xl_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_res_r <= xl_res;
    end
  end

  assign out_valid          = s2_valid_r;
  assign out_effect_present = s2_res_r.effect_present;
  assign out_format_error   = s2_res_r.format_error;
  assign out_format         = s2_res_r.fmt;
  assign out_command        = s2_res_r.cmd;
  assign out_info           = s2_res_r.info;
  assign out_volume_write   = s2_res_r.volume_write;
  assign out_volume_value   = s2_res_r.volume_value;
  assign out_keep_note      = s2_res_r.keep_note;
  assign out_keep_volume    = s2_res_r.keep_volume;

  // checks
  `TET_ASSERT_IMPLY(a_err_empty, out_valid && out_format_error, !out_effect_present && !out_volume_write, "format error beat carries an effect or volume write")
  `TET_ASSERT_IMPLY(a_vol_xor_fx, out_valid && out_volume_write, !out_effect_present, "volume write and effect in one beat")
  `TET_ASSERT_IMPLY(a_keep_needs_fx, out_valid && (out_keep_note || out_keep_volume), out_effect_present, "keep flag without effect")
  `TET_ASSERT_NEXT(a_stage_hold, s1_valid_r && s2_valid_r && out_stall, s1_valid_r && s2_valid_r, "beat lost while stalled")

endmodule

`default_nettype wire

// ===== tb/tracker_effect_translator_tb.sv =====
// testbench for tracker_effect_translator: directed table then random effects,
// each result beat checked against a hand-written expectation or a local translation predictor
// depends on tet_pkg and the tracker_effect_translator rtl
module tracker_effect_translator_tb;
  import tet_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_EFFECTS = 1800;
  localparam int unsigned REPORT_LIMIT = 10;

  // one directed stimulus row; fixed rows carry a hand-written expectation
  typedef struct {
    logic [1:0]  fmt;
    logic [7:0]  cmd;
    logic [7:0]  info;
    bit          fixed;
    tet_result_t res;
  } effect_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_source_format = FMT_MOD;
  logic [7:0] in_command = 8'h00;
  logic [7:0] in_info = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_effect_present;
  logic out_format_error;
  logic [1:0] out_format;
  logic [7:0] out_command;
  logic [7:0] out_info;
  logic out_volume_write;
  logic [7:0] out_volume_value;
  logic out_keep_note;
  logic out_keep_volume;

  tet_result_t pending_effects[$];
  effect_row_t directed_rows[$];
  tet_result_t seen_result;
  tet_result_t want_result;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;

  tracker_effect_translator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_source_format  (in_source_format),
    .in_command        (in_command),
    .in_info           (in_info),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_effect_present(out_effect_present),
    .out_format_error  (out_format_error),
    .out_format        (out_format),
    .out_command       (out_command),
    .out_info          (out_info),
    .out_volume_write  (out_volume_write),
    .out_volume_value  (out_volume_value),
    .out_keep_note     (out_keep_note),
    .out_keep_volume   (out_keep_volume)
  );

  always #1 clk = ~clk;

  // translation of one effect into the normalized letter form
  function automatic tet_result_t translate_effect(input logic [1:0] fmt,
                                                   input logic [7:0] cmd,
                                                   input logic [7:0] info);
    tet_result_t r;
    logic [3:0] lo;
    logic [3:0] sub;
    int unsigned pan;
    r = '0;
    lo = info[3:0];
    sub = info[7:4];
    case (fmt)
      FMT_MOD: begin
        if (cmd == MOD_SET_VOL) begin
          r.volume_write = 1'b1;
          r.volume_value = info;
        end else begin
          r.effect_present = 1'b1;
          r.fmt = FMT_S3M;
          r.cmd = cmd;
          r.info = info;
          case (cmd)
            MOD_ARPEGGIO: begin
              if (info == 8'h00) r.effect_present = 1'b0;
              else r.cmd = LTR_J;
            end
            MOD_PORTA_UP: begin
              r.cmd = LTR_F;
              if (info >= SLIDE_LIMIT) r.info = SLIDE_CLAMP;
            end
            MOD_PORTA_DN: begin
              r.cmd = LTR_E;
              if (info >= SLIDE_LIMIT) r.info = SLIDE_CLAMP;
            end
            MOD_TONE_PORTA: r.cmd = LTR_G;
            MOD_VIBRATO:    r.cmd = LTR_H;
            MOD_PORTA_VSL:  r.cmd = LTR_L;
            MOD_VIB_VSL:    r.cmd = LTR_K;
            MOD_TREMOLO:    r.cmd = LTR_R;
            MOD_PAN: begin
              // 0..255 pan scaled down to 0..128
              r.cmd = LTR_X;
              pan = (int'(info) * 128) / 255;
              r.info = pan[7:0];
            end
            MOD_OFFSET:    r.cmd = LTR_O;
            MOD_VOL_SLIDE: r.cmd = LTR_D;
            MOD_JUMP:      r.cmd = LTR_B;
            MOD_BREAK:     r.cmd = LTR_C;
            MOD_EXTENDED: begin
              case (sub)
                ESUB_FILTER: r.effect_present = 1'b0;
                ESUB_FINE_UP, ESUB_FINE_DN: begin
                  if (lo == 4'h0) begin
                    r.effect_present = 1'b0;
                  end else begin
                    r.cmd = (sub == ESUB_FINE_UP) ? LTR_F : LTR_E;
                    r.info = (lo == 4'hF) ? 8'hFE : {4'hF, lo};
                  end
                end
                ESUB_GLISS:     begin r.cmd = LTR_S; r.info = {4'h1, lo}; end
                ESUB_VIB_WAVE:  begin r.cmd = LTR_S; r.info = {4'h3, lo}; end
                ESUB_FINETUNE:  begin r.cmd = LTR_S; r.info = {4'h2, lo ^ 4'h8}; end
                ESUB_LOOP:      begin r.cmd = LTR_S; r.info = {4'hB, lo}; end
                ESUB_TREM_WAVE: begin r.cmd = LTR_S; r.info = {4'h4, lo}; end
                ESUB_RETRIG: begin
                  if (lo == 4'h0) begin
                    r.effect_present = 1'b0;
                  end else begin
                    r.cmd = LTR_Q;
                    r.info = {4'h0, lo};
                  end
                end
                ESUB_FVOL_UP: begin
                  r.cmd = LTR_D;
                  r.info = {(lo == 4'hF) ? 4'hE : lo, 4'hF};
                end
                ESUB_FVOL_DN: begin
                  r.cmd = LTR_D;
                  r.info = {4'hF, (lo == 4'hF) ? 4'hE : lo};
                end
                // invert loop passes through untouched
                ESUB_INVERT: ;
                default: r.cmd = LTR_S;
              endcase
            end
            MOD_SPEED: r.cmd = (info >= TEMPO_MIN) ? LTR_T : LTR_A;
            // commands above the mod range pass through
            default: ;
          endcase
          if (!r.effect_present) r = '0;
        end
      end
      FMT_S3M, FMT_IT: begin
        if (cmd >= LETTER_FIRST && cmd <= LETTER_LAST) begin
          r.effect_present = 1'b1;
          r.fmt = fmt;
          r.cmd = cmd + LETTER_BASE;
          r.info = info;
        end
      end
      default: r.format_error = 1'b1;
    endcase
    // note and volume keep flags follow the final letter
    if (r.effect_present) begin
      r.keep_note = (r.cmd == LTR_G || r.cmd == LTR_L);
      r.keep_volume = (r.cmd == LTR_D || r.cmd == LTR_K || r.cmd == LTR_L);
    end
    return r;
  endfunction

  function automatic void add_free(input logic [1:0] fmt, input logic [7:0] cmd,
                                   input logic [7:0] info);
    effect_row_t row;
    row.fmt = fmt;
    row.cmd = cmd;
    row.info = info;
    row.fixed = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_fixed(input logic [1:0] fmt, input logic [7:0] cmd,
                                    input logic [7:0] info, input tet_result_t res);
    effect_row_t row;
    row.fmt = fmt;
    row.cmd = cmd;
    row.info = info;
    row.fixed = 1'b1;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  // random effect, weighted toward mod commands and extended subcommands
  task automatic pick_effect(output logic [1:0] fmt, output logic [7:0] cmd,
                             output logic [7:0] info);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    info = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 5))
        0: info = 8'h00;
        1: info = 8'hFF;
        2: info = SLIDE_LIMIT;
        3: info = SLIDE_CLAMP;
        4: info = TEMPO_MIN;
        default: info = TEMPO_MIN - 8'd1;
      endcase
    end
    if (roll < 30) begin
      fmt = FMT_MOD;
      cmd = 8'($urandom_range(0, 15));
    end else if (roll < 55) begin
      // extended subcommand with the low nybble often at its edges
      fmt = FMT_MOD;
      cmd = MOD_EXTENDED;
      case ($urandom_range(0, 3))
        0: info[3:0] = 4'h0;
        1: info[3:0] = 4'hF;
        default: ;
      endcase
    end else if (roll < 60) begin
      fmt = FMT_MOD;
      cmd = 8'($urandom_range(0, 255));
    end else if (roll < 88) begin
      fmt = $urandom_range(0, 1) ? FMT_S3M : FMT_IT;
      cmd = 8'($urandom_range(0, 31));
    end else if (roll < 95) begin
      fmt = $urandom_range(0, 1) ? FMT_S3M : FMT_IT;
      cmd = 8'($urandom_range(0, 255));
    end else begin
      fmt = FMT_BAD;
      cmd = 8'($urandom_range(0, 255));
    end
  endtask

  // drive one input beat after a random gap (none while sender_calm) and wait for it to be taken
  task automatic send_effect(input logic [1:0] fmt, input logic [7:0] cmd,
                             input logic [7:0] info, input tet_result_t res);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_source_format <= fmt;
    in_command <= cmd;
    in_info <= info;
    do @(posedge clk); while (in_stall);
    pending_effects.push_back(res);
  endtask

  // stimulus
  initial begin : stimulus
    logic [1:0] fmt;
    logic [7:0] cmd;
    logic [7:0] info;
    effect_row_t row;

    add_fixed(FMT_MOD, MOD_ARPEGGIO, 8'h00, '0);
    add_free(FMT_MOD, MOD_ARPEGGIO, 8'h37);
    add_fixed(FMT_MOD, MOD_PORTA_UP, 8'hFF,
              '{1'b1, 1'b0, FMT_S3M, LTR_F, SLIDE_CLAMP, 1'b0, 8'h00, 1'b0, 1'b0});
    add_fixed(FMT_MOD, MOD_PORTA_DN, SLIDE_LIMIT,
              '{1'b1, 1'b0, FMT_S3M, LTR_E, SLIDE_CLAMP, 1'b0, 8'h00, 1'b0, 1'b0});
    add_free(FMT_MOD, MOD_TONE_PORTA, 8'h12);
    add_free(FMT_MOD, MOD_PORTA_VSL, 8'hA0);
    add_free(FMT_MOD, MOD_VIB_VSL, 8'h0F);
    add_fixed(FMT_MOD, MOD_PAN, 8'hFF,
              '{1'b1, 1'b0, FMT_S3M, LTR_X, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0});
    add_free(FMT_MOD, MOD_VOL_SLIDE, 8'hF0);
    add_fixed(FMT_MOD, MOD_SET_VOL, 8'hFF,
              '{1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0});
    add_free(FMT_MOD, MOD_SPEED, TEMPO_MIN - 8'd1);
    add_free(FMT_MOD, MOD_SPEED, TEMPO_MIN);
    add_fixed(FMT_MOD, 8'h10, 8'hAB,
              '{1'b1, 1'b0, FMT_S3M, 8'h10, 8'hAB, 1'b0, 8'h00, 1'b0, 1'b0});
    add_free(FMT_MOD, 8'hFF, 8'hFF);
    add_free(FMT_MOD, MOD_EXTENDED, {ESUB_FILTER, 4'h1});
    add_free(FMT_MOD, MOD_EXTENDED, {ESUB_FINE_DN, 4'h0});
    add_fixed(FMT_MOD, MOD_EXTENDED, {ESUB_FINE_DN, 4'hF},
              '{1'b1, 1'b0, FMT_S3M, LTR_E, 8'hFE, 1'b0, 8'h00, 1'b0, 1'b0});
    add_free(FMT_MOD, MOD_EXTENDED, {ESUB_FINE_DN, 4'h3});
    add_free(FMT_MOD, MOD_EXTENDED, {ESUB_FINETUNE, 4'hF});
    add_free(FMT_MOD, MOD_EXTENDED, {ESUB_FVOL_UP, 4'hF});
    add_free(FMT_MOD, MOD_EXTENDED, {ESUB_FVOL_DN, 4'hF});
    add_free(FMT_MOD, MOD_EXTENDED, {ESUB_INVERT, 4'h5});
    add_fixed(FMT_S3M, 8'h00, 8'h55, '0);
    add_fixed(FMT_S3M, LETTER_LAST, 8'hFF,
              '{1'b1, 1'b0, FMT_S3M, LETTER_BASE + LETTER_LAST, 8'hFF, 1'b0, 8'h00,
                1'b0, 1'b0});
    add_fixed(FMT_IT, LETTER_LAST + 8'd1, 8'h00, '0);
    add_free(FMT_IT, LETTER_FIRST, 8'h80);
    add_fixed(FMT_BAD, 8'hFF, 8'hFF,
              '{1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_effect(row.fmt, row.cmd, row.info,
                  row.fixed ? row.res : translate_effect(row.fmt, row.cmd, row.info));
    end

    // hold off until the pipeline has drained
    in_valid <= 1'b0;
    while (pending_effects.size() != 0) @(posedge clk);

    // random effects
    for (int n = 0; n < RANDOM_EFFECTS; n++) begin
      if ($urandom_range(0, 149) == 0) sender_calm = !sender_calm;
      if (n == RANDOM_EFFECTS / 2) begin
        in_valid <= 1'b0;
        while (pending_effects.size() != 0) @(posedge clk);
      end
      pick_effect(fmt, cmd, info);
      send_effect(fmt, cmd, info, translate_effect(fmt, cmd, info));
    end
    in_valid <= 1'b0;

    // drain, then give any stray beat time to show up
    while (pending_effects.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_effects.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result checker and random receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_result = '{out_effect_present, out_format_error, out_format, out_command,
                        out_info, out_volume_write, out_volume_value, out_keep_note,
                        out_keep_volume};
        if (pending_effects.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result beat: %p", seen_result);
        end else begin
          want_result = pending_effects.pop_front();
          if (seen_result !== want_result) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("result mismatch: expected %p actual %p", want_result, seen_result);
          end
        end
        hold_left = receiver_calm ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 149) == 0) receiver_calm = !receiver_calm;
      end
      out_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

// ===== tracker_effect_translator.f =====
+incdir+hdl
hdl/tet_pkg.sv
hdl/tet_mod_map.sv
hdl/tet_xlate.sv
hdl/tracker_effect_translator.sv
tb/tracker_effect_translator_tb.sv
